@@ rtl/fdm_pkg.sv @@
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared types and constants of the floored divide / modulo core.
// ----------------------------------------------------------------------------
package fdm_pkg;

  // operand and result width
  localparam int WIDTH = 32;

  // operand beat
  typedef struct packed {
    logic signed [WIDTH-1:0] dividend;
    logic signed [WIDTH-1:0] divisor;
  } fdm_in_t;

  // result beat
  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic signed [WIDTH-1:0] modulo;
    logic                    divide_by_zero;
  } fdm_out_t;

  // side information carried down the cell chain
  typedef struct packed {
    logic sa;  // dividend sign
    logic sb;  // divisor sign
    logic dz;  // divisor was zero
  } fdm_ctl_t;

endpackage

@@ rtl/fdm_cell.sv @@
// ----------------------------------------------------------------------------
// fdm_cell
// One restoring division step: shifts in the next dividend bit, tries the
// subtract and registers the partial remainder and the new quotient bit.
// ----------------------------------------------------------------------------
module fdm_cell #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  fdm_pkg::fdm_ctl_t ctl_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] aq_i,
  input  logic [WIDTH-1:0] mb_i,
  output logic             vld_o,
  output fdm_pkg::fdm_ctl_t ctl_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] aq_o,
  output logic [WIDTH-1:0] mb_o
);

  logic [WIDTH:0]    shifted;
  logic [WIDTH:0]    diff;
  logic              qbit;
  logic [WIDTH-1:0]  rem_nxt;
  logic [WIDTH-1:0]  aq_nxt;

  logic              vld_r;
  fdm_pkg::fdm_ctl_t ctl_r;
  logic [WIDTH-1:0]  rem_r;
  logic [WIDTH-1:0]  aq_r;
  logic [WIDTH-1:0]  mb_r;

  // trial subtract of the divisor magnitude
  always_comb begin
    shifted = {rem_i, aq_i[WIDTH-1]};
    diff    = shifted - {1'b0, mb_i};
    qbit    = ~diff[WIDTH];
    rem_nxt = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    aq_nxt  = {aq_i[WIDTH-2:0], qbit};
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ctl_r <= ctl_i;
    rem_r <= rem_nxt;
    aq_r  <= aq_nxt;
    mb_r  <= mb_i;
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign aq_o  = aq_r;
  assign mb_o  = mb_r;

endmodule

@@ rtl/fdm_fix.sv @@
// ----------------------------------------------------------------------------
// fdm_fix
// Turns the unsigned quotient and remainder magnitudes into the floored
// quotient and the modulo with the divisor's sign, and registers the result.
// ----------------------------------------------------------------------------
module fdm_fix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  fdm_pkg::fdm_ctl_t           ctl_i,
  input  logic [fdm_pkg::WIDTH-1:0]   qm_i,
  input  logic [fdm_pkg::WIDTH-1:0]   rm_i,
  input  logic [fdm_pkg::WIDTH-1:0]   mb_i,
  output logic                        out_valid,
  output fdm_pkg::fdm_out_t           out_data
);

  logic                      differ;
  logic                      rnz;
  logic [fdm_pkg::WIDTH-1:0] q_val;
  logic [fdm_pkg::WIDTH-1:0] r_val;
  fdm_pkg::fdm_out_t         res_nxt;

  logic                      vld_r;
  fdm_pkg::fdm_out_t         res_r;

  // sign restore and floor correction
  always_comb begin
    differ = ctl_i.sa ^ ctl_i.sb;
    rnz    = |rm_i;
    if (differ) begin
      // minus qm, lowered by one when a remainder is left: that is ~qm
      q_val = rnz ? ~qm_i : (~qm_i + 1'b1);
    end else begin
      q_val = qm_i;
    end
    if (differ && rnz) begin
      r_val = ctl_i.sb ? (rm_i - mb_i) : (mb_i - rm_i);
    end else begin
      r_val = ctl_i.sa ? (~rm_i + 1'b1) : rm_i;
    end
    if (ctl_i.dz) begin
      res_nxt.quotient       = '0;
      res_nxt.modulo         = '0;
      res_nxt.divide_by_zero = 1'b1;
    end else begin
      res_nxt.quotient       = q_val;
      res_nxt.modulo         = r_val;
      res_nxt.divide_by_zero = 1'b0;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = res_r;

endmodule

@@ rtl/floored_divide_modulo_core.sv @@
// ----------------------------------------------------------------------------
// floored_divide_modulo_core
// Signed floored divide and modulo over a pipelined chain of division cells.
// ----------------------------------------------------------------------------
// Takes one operand beat in every cycle (busy is high only during reset and
// the cycle after it) and returns each result through the operand register,
// the cells and the result register, as a one-cycle out_valid strobe that
// cannot be held off. The pipeline is the row of 32 restoring-division cells,
// one quotient bit per cell, plus one operand register in front for the
// magnitudes and one result register behind for the floor correction.
// A zero divisor returns quotient and modulo of zero with divide_by_zero set.
// ----------------------------------------------------------------------------
module floored_divide_modulo_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fdm_pkg::fdm_in_t  in_data,
  output logic              out_valid,
  output fdm_pkg::fdm_out_t out_data
);

  localparam int W = fdm_pkg::WIDTH;

  logic              accept;
  logic [W-1:0]      ma_nxt;
  logic [W-1:0]      mb_nxt;
  fdm_pkg::fdm_ctl_t ctl_nxt;

  logic              busy_r;
  logic              vld_r;
  fdm_pkg::fdm_ctl_t ctl_r;
  logic [W-1:0]      ma_r;
  logic [W-1:0]      mb_r;

  // chain taps, one more than the number of cells
  logic              vld_w [0:W];
  fdm_pkg::fdm_ctl_t ctl_w [0:W];
  logic [W-1:0]      rem_w [0:W];
  logic [W-1:0]      aq_w  [0:W];
  logic [W-1:0]      mb_w  [0:W];

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // operand magnitudes and signs
  always_comb begin
    ctl_nxt.sa = in_data.dividend[W-1];
    ctl_nxt.sb = in_data.divisor[W-1];
    ctl_nxt.dz = ~|in_data.divisor;
    ma_nxt = ctl_nxt.sa ? (~in_data.dividend + 1'b1) : in_data.dividend;
    mb_nxt = ctl_nxt.sb ? (~in_data.divisor + 1'b1) : in_data.divisor;
  end

  // operand register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  // operand register payload
  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
  end

  // head of the chain: empty remainder, dividend bits to shift in
  assign vld_w[0] = vld_r;
  assign ctl_w[0] = ctl_r;
  assign rem_w[0] = '0;
  assign aq_w[0]  = ma_r;
  assign mb_w[0]  = mb_r;

  // one cell per quotient bit
  for (genvar i = 0; i < W; i++) begin : g_cell
    fdm_cell #(
      .WIDTH (W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_w[i]),
      .ctl_i (ctl_w[i]),
      .rem_i (rem_w[i]),
      .aq_i  (aq_w[i]),
      .mb_i  (mb_w[i]),
      .vld_o (vld_w[i+1]),
      .ctl_o (ctl_w[i+1]),
      .rem_o (rem_w[i+1]),
      .aq_o  (aq_w[i+1]),
      .mb_o  (mb_w[i+1])
    );
  end

  // sign restore and result register
  fdm_fix u_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (vld_w[W]),
    .ctl_i     (ctl_w[W]),
    .qm_i      (aq_w[W]),
    .rm_i      (rem_w[W]),
    .mb_i      (mb_w[W]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fdm_checker.sv @@
// ----------------------------------------------------------------------------
// fdm_checker
// Port-level checks of the floored divide / modulo core, bound to the top.
// ----------------------------------------------------------------------------
module fdm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input fdm_pkg::fdm_in_t  in_data,
  input logic              out_valid,
  input fdm_pkg::fdm_out_t out_data
);

  localparam int LAT = fdm_pkg::WIDTH + 2;

  // zero-divisor results carry zero quotient and modulo
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      out_data.quotient == '0 && out_data.modulo == '0)
    else $error("divide by zero result not cleared");

  // every result strobe traces back to an accepted start beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without matching start beat");

  // a zero divisor comes out flagged
  a_dz_flag: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.divisor == '0 |->
      ##LAT out_valid && out_data.divide_by_zero)
    else $error("zero divisor not flagged");

  // division by one returns the dividend with modulo zero
  a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.divisor == fdm_pkg::WIDTH'(1) |->
      ##LAT out_valid && !out_data.divide_by_zero &&
      out_data.quotient == $past(in_data.dividend, LAT) && out_data.modulo == '0)
    else $error("division by one wrong");

  // the core never holds off operands once out of reset
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind floored_divide_modulo_core fdm_checker u_fdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
